FILE: design/smooth_position_tracker_unit_assert.svh
// Assertion macros for the smooth position tracker.
// Taken in by the top level; needs nothing else.
`ifndef SMOOTH_POSITION_TRACKER_UNIT_ASSERT_SVH
`define SMOOTH_POSITION_TRACKER_UNIT_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define SPT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/spt_pkg.sv
// Shared types and constants for the smooth position tracker.
// No dependencies; used by spt_datapath, the top level and the testbench.
`default_nettype none

package spt_pkg;

  localparam int FRACTION_BITS_DEF = 8;

  localparam int CMD_W   = 2;
  localparam int GOAL_W  = 12;
  localparam int POS_W   = 20;
  localparam int LIMIT_W = 13;
  localparam int GAIN_W  = 8;
  localparam int VEL_W   = 14;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = LIMIT_W;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  localparam logic [CFG_ADDR_W-1:0] REG_SPEED_LIMIT  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SPRING_GAIN  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DAMPING_GAIN = 2'd2;

  localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST  = 13'd3072;
  localparam logic [GAIN_W-1:0]  SPRING_GAIN_RST  = 8'd77;
  localparam logic [GAIN_W-1:0]  DAMPING_GAIN_RST = 8'd102;

  // Codes 2 and 3 pass the position through.
  typedef enum logic [CMD_W-1:0] {
    CMD_SLOW   = 2'd0,
    CMD_SPRING = 2'd1
  } cmd_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] speed_limit;
    logic [GAIN_W-1:0]  spring_gain;
    logic [GAIN_W-1:0]  damping_gain;
  } spt_cfg_t;

endpackage

`default_nettype wire

FILE: design/spt_datapath.sv
// One-frame position update: slow approach, spring step or pass through.
// Purely combinational; depends on spt_pkg.
`default_nettype none

module spt_datapath import spt_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic [CMD_W-1:0]        cmd,
  input  wire logic signed [GOAL_W-1:0] goal,
  input  wire logic signed [POS_W-1:0] pos,
  input  wire logic signed [VEL_W-1:0] vel,
  input  wire spt_cfg_t                cfg,
  output logic signed [POS_W-1:0]      pos_nxt,
  output logic signed [VEL_W-1:0]      vel_nxt,
  output logic                         settled
);

  localparam int GFW = GOAL_W + FRACTION_BITS;
  localparam int EW  = ((GFW > POS_W) ? GFW : POS_W) + 1;
  localparam int PW  = EW + GAIN_W + 1;
  localparam int VPW = VEL_W + GAIN_W + 1;
  localparam int AW  = ((PW > VPW) ? PW : VPW) + 1;
  localparam int SW  = VEL_W + 4;

  localparam logic signed [EW:0] POS_HI = (EW+1)'((64'sd1 <<< (POS_W-1)) - 64'sd1);
  localparam logic signed [EW:0] POS_LO = -((EW+1)'(64'sd1 <<< (POS_W-1)));
  localparam logic [EW-1:0] ONE_E = EW'(1) << FRACTION_BITS;
  localparam logic [SW-1:0] ONE_S = SW'(1) << FRACTION_BITS;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [EW:0] v);
    if (v > POS_HI) begin
      return POS_HI[POS_W-1:0];
    end else if (v < POS_LO) begin
      return POS_LO[POS_W-1:0];
    end
    return v[POS_W-1:0];
  endfunction

  logic signed [EW-1:0]  goal_ext;
  logic signed [EW-1:0]  goal_fx;
  logic signed [EW-1:0]  pos_ext;
  logic signed [EW-1:0]  err;
  logic [EW-1:0]         err_abs;
  logic signed [EW-1:0]  lim_e;
  logic signed [EW-1:0]  quarter;
  logic signed [EW-1:0]  step;
  logic signed [POS_W-1:0] snap_pos;
  logic signed [AW-1:0]  prod_err;
  logic signed [AW-1:0]  prod_vel;
  logic signed [AW-1:0]  diff;
  logic signed [AW-1:0]  acc;
  logic signed [AW-1:0]  vel_sum;
  logic signed [AW-1:0]  lim_a;
  logic signed [VEL_W-1:0] vel_c;
  logic [VEL_W-1:0]      vel_abs;
  logic [SW-1:0]         vel_x10;

  assign goal_ext = EW'(goal);
  assign goal_fx  = goal_ext <<< FRACTION_BITS;
  assign pos_ext  = EW'(pos);
  assign err      = goal_fx - pos_ext;
  assign err_abs  = err[EW-1] ? EW'(-err) : EW'(err);
  assign lim_e    = EW'($signed({1'b0, cfg.speed_limit}));
  assign lim_a    = AW'($signed({1'b0, cfg.speed_limit}));
  assign snap_pos = sat_pos((EW+1)'(goal_fx));

  // Slow approach: quarter of the error, rounded toward zero, then limited.
  assign quarter = (err + (err[EW-1] ? EW'(3) : EW'(0))) >>> 2;
  assign step    = (quarter > lim_e) ? lim_e : ((quarter < -lim_e) ? -lim_e : quarter);

  // Spring: gain products in Q0.8, divided by 256 toward zero.
  assign prod_err = AW'(err) * AW'($signed({1'b0, cfg.spring_gain}));
  assign prod_vel = AW'(vel) * AW'($signed({1'b0, cfg.damping_gain}));
  assign diff     = prod_err - prod_vel;
  assign acc      = (diff + (diff[AW-1] ? AW'(255) : AW'(0))) >>> 8;
  assign vel_sum  = AW'(vel) + acc;
  assign vel_c    = (vel_sum > lim_a) ? VEL_W'(lim_a) :
                    ((vel_sum < -lim_a) ? VEL_W'(-lim_a) : VEL_W'(vel_sum));
  assign vel_abs  = vel_c[VEL_W-1] ? VEL_W'(-vel_c) : VEL_W'(vel_c);
  assign vel_x10  = (SW'(vel_abs) << 3) + (SW'(vel_abs) << 1);

  always_comb begin
    pos_nxt = pos;
    vel_nxt = vel;
    case (cmd)
      CMD_SLOW: begin
        if (err_abs > ONE_E) begin
          pos_nxt = sat_pos((EW+1)'(pos_ext) + (EW+1)'(step));
        end else begin
          pos_nxt = snap_pos;
        end
      end
      CMD_SPRING: begin
        if ((err_abs < ONE_E) && (vel_x10 < ONE_S)) begin
          pos_nxt = snap_pos;
          vel_nxt = '0;
        end else begin
          pos_nxt = sat_pos((EW+1)'(pos_ext) + (EW+1)'(vel_c));
          vel_nxt = vel_c;
        end
      end
      default: begin
        pos_nxt = pos;
        vel_nxt = vel;
      end
    endcase
  end

  assign settled = (EW'(pos_nxt) == goal_fx);

endmodule

`default_nettype wire

FILE: design/smooth_position_tracker_unit.sv
// A request enters the input stage; its result is registered as that stage advances.
// Throughput: one request per cycle; the input stage advances whenever the result
// register is empty or being taken, and the spring velocity register closes a loop
// through the datapath so each request sees the previous update.
// Reset (rst_n low, synchronous): both stages empty, velocity zero, config registers
// back to speed limit 12.0, stiffness 0.3 and damping 0.4.
`default_nettype none
`include "smooth_position_tracker_unit_assert.svh"

module smooth_position_tracker_unit import spt_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // goal [11:0], position_in [31:12]
  input  wire logic [CMD_W-1:0]      in_tuser,   // command [1:0]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // position_out [19:0], zero [23:20]
  output logic [0:0]                 out_tuser,  // settled [0]
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  spt_cfg_t cfg_r, cfg_nxt;

  logic                    s1_valid_r, s1_valid_nxt;
  logic [CMD_W-1:0]        s1_cmd_r;
  logic signed [GOAL_W-1:0] s1_goal_r;
  logic signed [POS_W-1:0] s1_pos_r;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [POS_W-1:0] out_pos_r;
  logic                    out_settled_r;

  logic signed [VEL_W-1:0] vel_r;
  logic signed [VEL_W-1:0] vel_nxt;
  logic signed [POS_W-1:0] pos_nxt;
  logic                    settled_nxt;

  logic advance;
  logic in_fire;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_SPEED_LIMIT:  cfg_nxt.speed_limit  = cfg_wdata;
        REG_SPRING_GAIN:  cfg_nxt.spring_gain  = cfg_wdata[GAIN_W-1:0];
        REG_DAMPING_GAIN: cfg_nxt.damping_gain = cfg_wdata[GAIN_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    s1_valid_nxt  = in_fire || (s1_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && !out_tready);
  end

  spt_datapath #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_datapath (
    .cmd     (s1_cmd_r),
    .goal    (s1_goal_r),
    .pos     (s1_pos_r),
    .vel     (vel_r),
    .cfg     (cfg_r),
    .pos_nxt (pos_nxt),
    .vel_nxt (vel_nxt),
    .settled (settled_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_limit  <= SPEED_LIMIT_RST;
      cfg_r.spring_gain  <= SPRING_GAIN_RST;
      cfg_r.damping_gain <= DAMPING_GAIN_RST;
      s1_valid_r         <= 1'b0;
      out_valid_r        <= 1'b0;
      vel_r              <= '0;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      // commit the velocity only when the request moves on
      if (advance) begin
        vel_r <= vel_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_tuser;
      s1_goal_r <= in_tdata[GOAL_W-1:0];
      s1_pos_r  <= in_tdata[GOAL_W+POS_W-1:GOAL_W];
    end
    if (advance) begin
      out_pos_r     <= pos_nxt;
      out_settled_r <= settled_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-POS_W){1'b0}}, out_pos_r};
  assign out_tuser  = out_settled_r;

  `SPT_ASSERT_NEXT(a_vel_hold, clk, rst_n, !advance, vel_r == $past(vel_r), "velocity changed without a request moving on")
  `SPT_ASSERT_NEXT(a_vel_limit, clk, rst_n, advance && (s1_cmd_r == CMD_SPRING), ($signed({1'b0, vel_r[VEL_W-1] ? VEL_W'(-vel_r) : VEL_W'(vel_r)}) <= $signed({2'b0, cfg_r.speed_limit})), "spring velocity beyond speed limit")
  `SPT_ASSERT_SAME(a_stall_cause, clk, rst_n, !in_tready, s1_valid_r && out_valid_r && !out_tready, "input stalled while the pipeline can move")

endmodule

`default_nettype wire

FILE: tb/tb_smooth_position_tracker_unit.sv
// Self-checking testbench for smooth_position_tracker_unit: directed and random position
// requests, closed-loop trajectories and register phases, checked by a scoreboard class.
// Depends on spt_pkg and the smooth_position_tracker_unit top level.
`default_nettype none

module tb_smooth_position_tracker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import spt_pkg::*;

  localparam int FRACTION_BITS = FRACTION_BITS_DEF;
  localparam longint POS_MAX = (longint'(1) << (POS_W - 1)) - 1;
  localparam longint POS_MIN = -(longint'(1) << (POS_W - 1));
  // Codes 2 and 3 leave the position alone.
  localparam logic [CMD_W-1:0] CMD_PASS     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PASS_ALT = 2'd3;
  localparam int PHASES       = 7;
  localparam int PHASE_ITEMS  = 155;

  typedef struct {
    logic [POS_W-1:0] position;
    logic             settled;
  } tracker_move_t;

  class tracker_scoreboard;
    logic [LIMIT_W-1:0]      speed_limit  = SPEED_LIMIT_RST;
    logic [GAIN_W-1:0]       spring_gain  = SPRING_GAIN_RST;
    logic [GAIN_W-1:0]       damping_gain = DAMPING_GAIN_RST;
    logic signed [VEL_W-1:0] velocity     = '0;
    logic signed [POS_W-1:0] last_position = '0;
    tracker_move_t           expected_moves[$];
    int                      error_count = 0;

    static function longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    static function longint saturate(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_SPEED_LIMIT:  speed_limit  = val[LIMIT_W-1:0];
        REG_SPRING_GAIN:  spring_gain  = val[GAIN_W-1:0];
        REG_DAMPING_GAIN: damping_gain = val[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    // Work out the next position for one accepted request and queue it.
    function void note_request(logic [CMD_W-1:0] cmd, logic signed [GOAL_W-1:0] goal,
                               logic signed [POS_W-1:0] pos_in);
      longint unity, goal_fx, pos, err, lim, vel, accel;
      tracker_move_t move;
      unity   = longint'(1) << FRACTION_BITS;
      goal_fx = longint'(goal) * unity;
      pos     = longint'(pos_in);
      lim     = longint'(speed_limit);
      err     = goal_fx - pos;
      if (cmd == CMD_SLOW) begin
        if (mag(err) > unity)
          pos = saturate(pos + saturate(err / 4, -lim, lim), POS_MIN, POS_MAX);
        else
          pos = saturate(goal_fx, POS_MIN, POS_MAX);
      end else if (cmd == CMD_SPRING) begin
        vel   = longint'(velocity);
        accel = (err * longint'(spring_gain) - vel * longint'(damping_gain)) / 256;
        vel   = saturate(vel + accel, -lim, lim);
        pos   = saturate(pos + vel, POS_MIN, POS_MAX);
        // Snap when close and nearly at rest.
        if (mag(err) < unity && mag(vel) * 10 < unity) begin
          pos = saturate(goal_fx, POS_MIN, POS_MAX);
          vel = 0;
        end
        velocity = vel[VEL_W-1:0];
      end
      move.position = pos[POS_W-1:0];
      move.settled  = (pos == goal_fx);
      last_position = pos[POS_W-1:0];
      expected_moves.push_back(move);
    endfunction

    function void check_result(logic [POS_W-1:0] position, logic settled);
      tracker_move_t move;
      if (expected_moves.size() == 0) begin
        $error("unexpected result: position_out %0h settled %0b", position, settled);
        error_count++;
        return;
      end
      move = expected_moves.pop_front();
      if (position !== move.position) begin
        $error("position_out: expected %0d, actual %0d",
               $signed(move.position), $signed(position));
        error_count++;
      end
      if (settled !== move.settled) begin
        $error("settled: expected %0b, actual %0b", move.settled, settled);
        error_count++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // goal [11:0], position_in [31:12]
  logic [CMD_W-1:0]      in_tuser;   // command [1:0]
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // position_out [19:0], zero [23:20]
  logic [0:0]            out_tuser;  // settled [0]
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tracker_scoreboard sb = new();
  int burst_left = 0;

  smooth_position_tracker_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("FAIL");
    $finish;
  end

  // Receiver: ready pattern changes every stretch of cycles.
  initial begin
    int mode;
    int span;
    out_tready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_tready = 1'b1;
          1: out_tready = ($urandom_range(0, 1) == 0);
          2: out_tready = ($urandom_range(0, 3) == 0);
          default: out_tready = (span % 7 == 0) ? 1'b0 : ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[POS_W-1:0], out_tuser[0]);
  end

  task automatic send_request(logic [CMD_W-1:0] cmd, logic signed [GOAL_W-1:0] goal,
                              logic signed [POS_W-1:0] pos);
    int gap;
    // Insert a gap between bursts; now and then a long burst without gaps.
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 20);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {pos, goal};
    do @(posedge clk); while (!in_tready);
    sb.note_request(cmd, goal, pos);
    burst_left--;
  endtask

  // Feed each new position back as the next request, as a frame loop would.
  task automatic run_trajectory(logic [CMD_W-1:0] cmd, logic signed [GOAL_W-1:0] goal,
                                logic signed [POS_W-1:0] first_pos, int frames);
    send_request(cmd, goal, first_pos);
    repeat (frames - 1) send_request(cmd, goal, sb.last_position);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.expected_moves.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    int sent;
    int frames;
    logic [CMD_W-1:0] cmd;
    logic signed [GOAL_W-1:0] goal;
    logic signed [POS_W-1:0] start;
    longint near;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Field extremes, snap boundaries, saturation both ways, pass-through codes.
    send_request(CMD_SLOW, GOAL_W'(2047), POS_W'(-524288));
    send_request(CMD_SLOW, GOAL_W'(-2048), POS_W'(524287));
    send_request(CMD_SLOW, GOAL_W'(10), POS_W'(2816));
    send_request(CMD_SLOW, GOAL_W'(10), POS_W'(2303));
    send_request(CMD_SLOW, GOAL_W'(5), POS_W'(1283));
    send_request(CMD_SLOW, GOAL_W'(0), POS_W'(0));
    send_request(CMD_SPRING, GOAL_W'(2047), POS_W'(-524288));
    send_request(CMD_SPRING, GOAL_W'(2047), POS_W'(-524288));
    send_request(CMD_SPRING, GOAL_W'(2047), POS_W'(524287));
    send_request(CMD_SPRING, GOAL_W'(-2048), POS_W'(524287));
    send_request(CMD_SPRING, GOAL_W'(-2048), POS_W'(524287));
    send_request(CMD_SPRING, GOAL_W'(-2048), POS_W'(-524288));
    send_request(CMD_PASS, GOAL_W'(100), POS_W'(25600));
    send_request(CMD_PASS_ALT, GOAL_W'(-5), POS_W'(12345));
    run_trajectory(CMD_SPRING, GOAL_W'(3), POS_W'(0), 10);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        drain();
        case (phase)
          1: begin
            cfg_write(REG_SPEED_LIMIT, CFG_DATA_W'(8191));
            cfg_write(REG_SPRING_GAIN, CFG_DATA_W'(255));
            cfg_write(REG_DAMPING_GAIN, CFG_DATA_W'(255));
          end
          2: begin
            cfg_write(REG_SPEED_LIMIT, CFG_DATA_W'(0));
            cfg_write(REG_SPRING_GAIN, CFG_DATA_W'(0));
            cfg_write(REG_DAMPING_GAIN, CFG_DATA_W'(0));
          end
          3: begin
            cfg_write(REG_SPEED_LIMIT, CFG_DATA_W'(1));
            cfg_write(REG_SPRING_GAIN, CFG_DATA_W'(255));
            cfg_write(REG_DAMPING_GAIN, CFG_DATA_W'(0));
          end
          4: begin
            cfg_write(REG_SPEED_LIMIT, CFG_DATA_W'(8191));
            cfg_write(REG_SPRING_GAIN, CFG_DATA_W'(0));
            cfg_write(REG_DAMPING_GAIN, CFG_DATA_W'(255));
          end
          5: begin
            cfg_write(REG_SPEED_LIMIT, SPEED_LIMIT_RST);
            cfg_write(REG_SPRING_GAIN, CFG_DATA_W'(SPRING_GAIN_RST));
            cfg_write(REG_DAMPING_GAIN, CFG_DATA_W'(DAMPING_GAIN_RST));
          end
          default: begin
            cfg_write(REG_SPEED_LIMIT, CFG_DATA_W'($urandom_range(0, 8191)));
            cfg_write(REG_SPRING_GAIN, CFG_DATA_W'($urandom_range(0, 255)));
            cfg_write(REG_DAMPING_GAIN, CFG_DATA_W'($urandom_range(0, 255)));
          end
        endcase
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        goal = GOAL_W'($urandom());
        if ($urandom_range(0, 9) < 7) begin
          cmd    = ($urandom_range(0, 3) == 0) ? CMD_SLOW : CMD_SPRING;
          frames = $urandom_range(4, 40);
          case ($urandom_range(0, 2))
            0: start = sb.last_position;
            1: start = POS_W'($urandom());
            default: begin
              near  = longint'(goal) * (longint'(1) << FRACTION_BITS)
                      + $urandom_range(0, 4000) - 2000;
              near  = tracker_scoreboard::saturate(near, POS_MIN, POS_MAX);
              start = near[POS_W-1:0];
            end
          endcase
          run_trajectory(cmd, goal, start, frames);
          sent += frames;
        end else begin
          cmd = CMD_W'($urandom_range(0, 3));
          if ($urandom_range(0, 1) == 0) begin
            start = POS_W'($urandom());
          end else begin
            near  = longint'(goal) * (longint'(1) << FRACTION_BITS)
                    + $urandom_range(0, 600) - 300;
            near  = tracker_scoreboard::saturate(near, POS_MIN, POS_MAX);
            start = near[POS_W-1:0];
          end
          send_request(cmd, goal, start);
          sent++;
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.error_count == 0 && sb.expected_moves.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+design
design/spt_pkg.sv
design/spt_datapath.sv
design/smooth_position_tracker_unit.sv
tb/tb_smooth_position_tracker_unit.sv
